### hdl/request_deque_with_random_drop_macros.svh
// Assertion macros shared by the request deque checker.
`ifndef REQUEST_DEQUE_WITH_RANDOM_DROP_MACROS_SVH
`define REQUEST_DEQUE_WITH_RANDOM_DROP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RQD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RQD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rqd_pkg.sv
// Shared types, command codes and word layout of the request deque.
package rqd_pkg;

    localparam int CONN_W  = 16;
    localparam int SEC_W   = 32;
    localparam int USEC_W  = 20;
    localparam int CMD_W   = 3;
    localparam int DROP_W  = 7;
    localparam int OCC_W   = 7;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = CONN_W + SEC_W + USEC_W;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 80;
    localparam int LFSR_W  = 32;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

    // input command codes on s_tuser
    localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DROP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // result word bit positions
    localparam int OUT_VALID_BIT = ENTRY_W;
    localparam int OUT_CLOSE_BIT = ENTRY_W + 1;
    localparam int OUT_STAT_LO   = ENTRY_W + 2;
    localparam int OUT_OCC_LO    = ENTRY_W + 4;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DROP,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CONN_W-1:0] conn;
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
        logic              close;
        logic [DROP_W-1:0] drops;
    } req_t;

endpackage

### hdl/rqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rqd_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/rqd_front.sv
// Front end: takes input words, decodes the command and queues the request.
module rqd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rqd_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [rqd_pkg::CMD_W-1:0]       s_tuser,
    output logic                            q_valid,
    output rqd_pkg::req_t                   q_req,
    input  logic                            q_pop
);

    rqd_pkg::req_t req_in;
    rqd_pkg::req_t fifo_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          wr_en;

    always_comb begin
        case (s_tuser)
            rqd_pkg::CMD_PUSH:      req_in.op = rqd_pkg::OP_PUSH;
            rqd_pkg::CMD_POP_FRONT: req_in.op = rqd_pkg::OP_POP_FRONT;
            rqd_pkg::CMD_POP_BACK:  req_in.op = rqd_pkg::OP_POP_BACK;
            rqd_pkg::CMD_DROP:      req_in.op = rqd_pkg::OP_DROP;
            rqd_pkg::CMD_READ:      req_in.op = rqd_pkg::OP_READ;
            rqd_pkg::CMD_CLEAR:     req_in.op = rqd_pkg::OP_CLEAR;
            default:                req_in.op = rqd_pkg::OP_NOP;
        endcase
        req_in.conn  = s_tdata[15:0];
        req_in.sec   = s_tdata[47:16];
        req_in.usec  = s_tdata[67:48];
        req_in.close = s_tdata[68];
        req_in.drops = s_tdata[75:69];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign wr_en    = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (wr_en) begin
                fifo_reg[wr_ptr_reg] <= req_in;
                wr_ptr_reg           <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(q_pop);
        end
    end

endmodule

### hdl/rqd_back.sv
// Back end: executes queued requests on the entry store and emits result words.
module rqd_back #(
    parameter int CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  rqd_pkg::req_t                q_req,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rqd_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = rqd_pkg::OCC_W;
    localparam int EW = rqd_pkg::ENTRY_W;
    localparam int LW = rqd_pkg::LFSR_W;
    localparam logic [IW:0]   CAP_W = (IW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE, S_DISP, S_LFSR, S_DIV, S_RD, S_RES, S_SHR, S_SHW
    } state_t;

    state_t                       state_reg;
    logic [IW-1:0]                head_reg;
    logic [CW-1:0]                count_reg;
    logic [LW-1:0]                lfsr_reg;
    logic [LW-1:0]                div_reg;
    logic [CW-1:0]                rem_reg;
    logic [4:0]                   bit_reg;
    logic [IW-1:0]                pos_reg;
    rqd_pkg::req_t                req_reg;
    logic                         m_valid_reg;
    logic [rqd_pkg::M_DATA_W-1:0] m_data_reg;
    logic                         m_last_reg;

    logic                         out_free;
    logic [IW-1:0]                slot_pos;
    logic [IW-1:0]                slot_pos1;
    logic [IW-1:0]                slot_push;
    logic [IW-1:0]                head_inc;
    logic [LW-1:0]                lfsr_next;
    logic [CW:0]                  div_trial;
    logic [CW-1:0]                rem_next;
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    logic [EW-1:0]                ram_wdata;
    logic [IW-1:0]                ram_raddr;
    logic [EW-1:0]                ram_rdata;
    logic                         more_work;
    logic                         need_shift;

    function automatic logic [IW-1:0] wrap(input logic [IW:0] s);
        if (s >= CAP_W) begin
            return IW'(s - CAP_W);
        end
        return IW'(s);
    endfunction

    function automatic logic [rqd_pkg::M_DATA_W-1:0] blank_word(
        input logic [rqd_pkg::STAT_W-1:0] stat,
        input logic [OW-1:0]              occ
    );
        return {1'b0, occ, stat, 2'b00, {EW{1'b0}}};
    endfunction

    assign out_free  = !m_valid_reg || m_tready;
    assign slot_pos  = wrap({1'b0, head_reg} + {1'b0, pos_reg});
    assign slot_pos1 = wrap({1'b0, head_reg} + {1'b0, pos_reg} + (IW + 1)'(1));
    assign slot_push = wrap({1'b0, head_reg} + (IW + 1)'(count_reg));
    assign head_inc  = wrap({1'b0, head_reg} + (IW + 1)'(1));
    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? rqd_pkg::LFSR_TAPS : '0);

    // one restoring step of the remainder per cycle
    assign div_trial = {rem_reg, div_reg[LW-1]};
    assign rem_next  = (div_trial >= {1'b0, count_reg}) ?
                       CW'(div_trial - {1'b0, count_reg}) : CW'(div_trial);

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    assign more_work = ((req_reg.op == rqd_pkg::OP_CLEAR) && (count_reg > CW'(1))) ||
                       ((req_reg.op == rqd_pkg::OP_DROP) &&
                        (req_reg.drops > 7'd1) && (count_reg > CW'(1)));
    assign need_shift = (pos_reg != '0) && ((CW'(pos_reg) + CW'(1)) < count_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_pos;
        ram_wdata = ram_rdata;
        ram_raddr = (state_reg == S_SHR) ? slot_pos1 : slot_pos;
        if ((state_reg == S_DISP) && (req_reg.op == rqd_pkg::OP_PUSH) && out_free &&
            (count_reg != CAP_C)) begin
            ram_we    = 1'b1;
            ram_waddr = slot_push;
            ram_wdata = {req_reg.usec, req_reg.sec, req_reg.conn};
        end else if (state_reg == S_SHW) begin
            ram_we = 1'b1;
        end
    end

    rqd_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            lfsr_reg    <= LW'(1);
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        req_reg   <= q_req;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (req_reg.op)
                        rqd_pkg::OP_PUSH: begin
                            if (out_free) begin
                                m_valid_reg <= 1'b1;
                                m_last_reg  <= 1'b1;
                                state_reg   <= S_IDLE;
                                if (count_reg == CAP_C) begin
                                    m_data_reg <= blank_word(rqd_pkg::STAT_FULL,
                                                             OW'(count_reg));
                                end else begin
                                    count_reg  <= count_reg + CW'(1);
                                    m_data_reg <= blank_word(rqd_pkg::STAT_OK,
                                                             OW'(count_reg + CW'(1)));
                                end
                            end
                        end
                        rqd_pkg::OP_POP_FRONT, rqd_pkg::OP_POP_BACK,
                        rqd_pkg::OP_READ, rqd_pkg::OP_CLEAR: begin
                            if (count_reg == '0) begin
                                if (out_free) begin
                                    m_valid_reg <= 1'b1;
                                    m_last_reg  <= 1'b1;
                                    m_data_reg  <= blank_word(rqd_pkg::STAT_EMPTY, '0);
                                    state_reg   <= S_IDLE;
                                end
                            end else begin
                                pos_reg   <= (req_reg.op == rqd_pkg::OP_POP_BACK) ?
                                             IW'(count_reg - CW'(1)) : '0;
                                state_reg <= S_RD;
                            end
                        end
                        rqd_pkg::OP_DROP: begin
                            if ((req_reg.drops == '0) || (count_reg == '0)) begin
                                if (out_free) begin
                                    m_valid_reg <= 1'b1;
                                    m_last_reg  <= 1'b1;
                                    m_data_reg  <= blank_word((count_reg == '0) ?
                                                   rqd_pkg::STAT_EMPTY : rqd_pkg::STAT_OK,
                                                   OW'(count_reg));
                                    state_reg   <= S_IDLE;
                                end
                            end else begin
                                state_reg <= S_LFSR;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                m_valid_reg <= 1'b1;
                                m_last_reg  <= 1'b1;
                                m_data_reg  <= blank_word(rqd_pkg::STAT_OK, OW'(count_reg));
                                state_reg   <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_LFSR: begin
                    lfsr_reg  <= lfsr_next;
                    div_reg   <= lfsr_next;
                    rem_reg   <= '0;
                    bit_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg <= rem_next;
                    div_reg <= div_reg << 1;
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd31) begin
                        pos_reg   <= IW'(rem_next);
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_RES;
                end
                S_RES: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (req_reg.op == rqd_pkg::OP_READ) begin
                            m_last_reg <= 1'b1;
                            m_data_reg <= {1'b0, OW'(count_reg), rqd_pkg::STAT_OK,
                                           1'b0, 1'b1, ram_rdata};
                            state_reg  <= S_IDLE;
                        end else begin
                            m_last_reg    <= !more_work;
                            m_data_reg    <= {1'b0, OW'(count_reg - CW'(1)), rqd_pkg::STAT_OK,
                                              req_reg.close, 1'b1, ram_rdata};
                            count_reg     <= count_reg - CW'(1);
                            req_reg.drops <= req_reg.drops - 7'd1;
                            if (pos_reg == '0) begin
                                head_reg <= head_inc;
                            end
                            if (need_shift) begin
                                state_reg <= S_SHR;
                            end else if (!more_work) begin
                                state_reg <= S_IDLE;
                            end else if (req_reg.op == rqd_pkg::OP_CLEAR) begin
                                state_reg <= S_RD;
                            end else begin
                                state_reg <= S_LFSR;
                            end
                        end
                    end
                end
                S_SHR: begin
                    state_reg <= S_SHW;
                end
                S_SHW: begin
                    // move one entry toward the front, then advance
                    pos_reg <= pos_reg + IW'(1);
                    if ((CW'(pos_reg) + CW'(1)) < count_reg) begin
                        state_reg <= S_SHR;
                    end else if ((req_reg.op == rqd_pkg::OP_DROP) &&
                                 (req_reg.drops != '0) && (count_reg != '0)) begin
                        state_reg <= S_LFSR;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### hdl/request_deque_with_random_drop.sv
// Top level of the bounded request deque with random drop.
//
// Requests enter on the s_ channel: s_tuser carries the command, s_tdata the
// connection id, arrival time, close flag and drop count. A two-word queue
// behind s_tready decouples intake from execution, so up to two commands
// can wait while the engine is busy.
// Results leave on the m_ channel, one word per removed or read entry (or a
// single status word), with m_tlast on the final word of each command.
// The engine runs one command at a time. Push and commands that find the
// queue empty answer from the dispatch state; pop and read first read the
// entry store. Clear reads out and removes the entries one by one. A random
// drop picks each entry by the bit-serial remainder of the LFSR value by the
// occupancy, then moves every entry behind the gap toward the front with a
// read and a write of the entry store, whose read data is registered.
// Reset empties the queue and reloads the LFSR with one; stored entries are
// not cleared. A stalled m_ side holds the result word and the engine waits
// at its next result word; intake continues until the two-word queue is full.
module request_deque_with_random_drop #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // conn_id, arrival_sec, arrival_usec, close_on_remove, drop_count, zero pad
    input  logic [79:0] s_tdata,
    // command
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // entry_conn, entry_sec, entry_usec, entry_valid, close_conn, status,
    // occupancy, zero pad
    output logic [79:0] m_tdata,
    output logic        m_tlast
);

    logic          q_valid;
    logic          q_pop;
    rqd_pkg::req_t q_req;

    rqd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop)
    );

    rqd_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### hdl/rqd_checker.sv
// Port-level checks of the request deque result channel, bound to the top level.
`include "request_deque_with_random_drop_macros.svh"

module rqd_checker #(
    parameter int CAPACITY = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast
);

    localparam int VB = rqd_pkg::OUT_VALID_BIT;
    localparam int CB = rqd_pkg::OUT_CLOSE_BIT;
    localparam int SL = rqd_pkg::OUT_STAT_LO;
    localparam int OL = rqd_pkg::OUT_OCC_LO;

    `RQD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")
    `RQD_ASSERT_NOW(a_occ_bound, m_tvalid, m_tdata[OL+6:OL] <= 7'(CAPACITY), "occupancy above capacity")
    `RQD_ASSERT_NOW(a_blank_zero, m_tvalid && !m_tdata[VB], m_tdata[VB-1:0] == '0 && !m_tdata[CB], "blank result carries entry data")
    `RQD_ASSERT_NOW(a_full, m_tvalid && (m_tdata[SL+1:SL] == rqd_pkg::STAT_FULL), m_tlast && !m_tdata[VB] && (m_tdata[OL+6:OL] == 7'(CAPACITY)), "full status without a full queue")
    `RQD_ASSERT_NOW(a_empty_last, m_tvalid && (m_tdata[SL+1:SL] == rqd_pkg::STAT_EMPTY), m_tlast && (m_tdata[OL+6:OL] == '0), "empty status on a nonempty queue")

endmodule

bind request_deque_with_random_drop rqd_checker #(.CAPACITY(CAPACITY)) u_rqd_checker (.*);
